>>> rtl/core/prf_pkg.sv
// Shared types, constants and helper functions for the repulsive force block.
// Used by pairwise_repulsive_force and prf_div under rtl/core; depends on nothing.
`default_nettype none
package prf_pkg;

    // Default node capacity
    localparam int DEF_MAX_NODES = 64;

    // Reset value of the strength register: 1.0 in Q16.16
    localparam logic [31:0] K_RESET = 32'd65536;

    // Squared distance below 1e-6 (Q32.32 raw) counts as coincident
    localparam logic [63:0] NEAR_THRESH = 64'd4295;
    // Substitute squared distance of 1.0 (Q32.32)
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    // Substitute delta magnitude of 0.01 (Q16.16)
    localparam logic signed [32:0] NEAR_DELTA = 33'sd655;
    // Largest term magnitude
    localparam logic [63:0] QCAP = 64'h7FFF_FFFF_FFFF_FFFF;

    // Dividend width: 64-bit product shifted up by 16
    localparam int NUM_W = 80;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last_node;
    } node_in_t;

    typedef struct packed {
        logic [5:0]         node_index;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic               last_result;
    } force_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_I,
        S_LD_I,
        S_NEXT_J,
        S_LD_J,
        S_SQX,
        S_SQY,
        S_SUM,
        S_MULX,
        S_DIVX,
        S_WAITX,
        S_MULY,
        S_DIVY,
        S_WAITY,
        S_EMIT
    } prf_state_t;

    // Saturating signed 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Clamp signed 64-bit value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/pairwise_repulsive_force.sv
// Pairwise repulsive force: node stores, sequencer, shared multiplier, accumulators.
// Depends on prf_pkg, prf_ram and prf_div.
//
// Load node positions one transaction at a time (start while busy is low); a
// transaction with last_node set begins the run, and busy stays high until the
// final result. One result per stored node appears in index order, each for a
// single cycle under result_valid, and the receiver cannot stall them. Each
// node pair needs two quotients from the bit-serial divider, and the 32x32
// multiplier is shared by the squared distance and the two force products.
// Loading accepts one node per cycle while busy is low. Nodes beyond MAX_NODES
// are dropped. The strength register may be written whenever busy is low.
`default_nettype none
module pairwise_repulsive_force #(
    parameter int MAX_NODES = prf_pkg::DEF_MAX_NODES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire prf_pkg::node_in_t    in_item,
    output logic                      busy,
    output logic                      result_valid,
    output prf_pkg::force_out_t       result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [31:0]          cfg_data
);
    import prf_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    prf_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [31:0]   k_reg, k_next;

    logic signed [31:0] xi_reg, xi_next;
    logic signed [31:0] yi_reg, yi_next;
    logic signed [32:0] dx_reg, dx_next;
    logic signed [32:0] dy_reg, dy_next;
    logic [63:0]        den_reg, den_next;
    logic [63:0]        prod_reg, prod_next;
    logic signed [63:0] sx_reg, sx_next;
    logic signed [63:0] sy_reg, sy_next;

    logic          accept;
    logic          we;
    logic [AW-1:0] raddr;
    logic [31:0]   xr, yr;
    logic [32:0]   ndx, ndy;
    logic [31:0]   dx_abs, dy_abs;
    logic [31:0]   mul_a, mul_b;
    logic [64:0]   dsum;
    logic [63:0]   dsat;
    logic          div_start;
    logic          div_done;
    logic [63:0]   div_quot;
    logic signed [63:0] term;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;
    assign we        = accept && (count_reg < CW'(MAX_NODES));
    assign raddr     = (state_reg == S_RD_I) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    prf_ram #(.WIDTH(32), .DEPTH(MAX_NODES), .AW(AW)) u_x_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_item.pos_x),
        .raddr (raddr),
        .rdata (xr)
    );

    prf_ram #(.WIDTH(32), .DEPTH(MAX_NODES), .AW(AW)) u_y_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_item.pos_y),
        .raddr (raddr),
        .rdata (yr)
    );

    prf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Magnitudes of the deltas; they never exceed 2^32 - 1
    always_comb
    begin
        ndx    = -dx_reg;
        ndy    = -dy_reg;
        dx_abs = dx_reg[32] ? ndx[31:0] : dx_reg[31:0];
        dy_abs = dy_reg[32] ? ndy[31:0] : dy_reg[31:0];
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = dx_abs;
                mul_b = dx_abs;
            end
            S_SQY:
            begin
                mul_a = dy_abs;
                mul_b = dy_abs;
            end
            S_MULX:
            begin
                mul_a = dx_abs;
                mul_b = k_reg;
            end
            default:
            begin
                mul_a = dy_abs;
                mul_b = k_reg;
            end
        endcase
    end

    // Squared distance, saturated
    always_comb
    begin
        dsum = {1'b0, den_reg} + {1'b0, prod_reg};
        dsat = dsum[64] ? {64{1'b1}} : dsum[63:0];
    end

    // Signed term from the divider
    always_comb
    begin
        if (state_reg == S_WAITX)
            term = dx_reg[32] ? -$signed(div_quot) : $signed(div_quot);
        else
            term = dy_reg[32] ? -$signed(div_quot) : $signed(div_quot);
    end

    assign div_start = (state_reg == S_DIVX) || (state_reg == S_DIVY);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        xi_next    = xi_reg;
        yi_next    = yi_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        den_next   = den_reg;
        prod_next  = prod_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;

        if (cfg_valid && cfg_ready)
            k_next = cfg_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (we)
                        count_next = count_reg + CW'(1);
                    if (in_item.last_node)
                    begin
                        i_next     = '0;
                        state_next = S_RD_I;
                    end
                end
            end
            S_RD_I:
                state_next = S_LD_I;
            S_LD_I:
            begin
                xi_next    = xr;
                yi_next    = yr;
                sx_next    = '0;
                sy_next    = '0;
                j_next     = '0;
                state_next = S_NEXT_J;
            end
            S_NEXT_J:
            begin
                if (j_reg == count_reg)
                    state_next = S_EMIT;
                else if (j_reg == i_reg)
                    j_next = j_reg + CW'(1);
                else
                    state_next = S_LD_J;
            end
            S_LD_J:
            begin
                dx_next    = {xi_reg[31], xi_reg} - {xr[31], xr};
                dy_next    = {yi_reg[31], yi_reg} - {yr[31], yr};
                state_next = S_SQX;
            end
            S_SQX:
            begin
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_SQY;
            end
            S_SQY:
            begin
                den_next   = prod_reg;
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // Coincident nodes: unit distance, fixed push by index order
                if (dsat < NEAR_THRESH)
                begin
                    den_next = ONE_Q32;
                    dx_next  = (i_reg > j_reg) ? NEAR_DELTA : -NEAR_DELTA;
                    dy_next  = (i_reg > j_reg) ? NEAR_DELTA : -NEAR_DELTA;
                end
                else
                    den_next = dsat;
                state_next = S_MULX;
            end
            S_MULX:
            begin
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_DIVX;
            end
            S_DIVX:
                state_next = S_WAITX;
            S_WAITX:
            begin
                if (div_done)
                begin
                    sx_next    = sat_add64(sx_reg, term);
                    state_next = S_MULY;
                end
            end
            S_MULY:
            begin
                prod_next  = {32'b0, mul_a} * {32'b0, mul_b};
                state_next = S_DIVY;
            end
            S_DIVY:
                state_next = S_WAITY;
            S_WAITY:
            begin
                if (div_done)
                begin
                    sy_next    = sat_add64(sy_reg, term);
                    j_next     = j_reg + CW'(1);
                    state_next = S_NEXT_J;
                end
            end
            S_EMIT:
            begin
                if (i_reg + CW'(1) == count_reg)
                begin
                    count_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_RD_I;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= K_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Hold datapath values
    always_ff @(posedge clk)
    begin
        xi_reg   <= xi_next;
        yi_reg   <= yi_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        den_reg  <= den_next;
        prod_reg <= prod_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
    end

    // Drive the result transaction
    assign result_valid       = (state_reg == S_EMIT);
    assign result.node_index  = 6'(i_reg);
    assign result.force_x     = sat32(sx_reg);
    assign result.force_y     = sat32(sy_reg);
    assign result.last_result = (i_reg + CW'(1) == count_reg);

    // A result only ever appears during a run
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result outside a run");

    // The final result ends the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_result) |=> !busy)
        else $error("run continues after final result");

    // A last-node transaction starts a run
    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.last_node) |=> busy)
        else $error("last node did not start a run");

    // The divider never reports done straight after a start
    a_div_start_ok: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> !div_done)
        else $error("divider done straight after start");

endmodule
`default_nettype wire

>>> rtl/core/prf_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
`default_nettype none
module prf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/prf_div.sv
// Bit-serial restoring divider: floor(num * 2^16 / den), saturated to 2^63 - 1.
// One quotient bit per cycle; depends on prf_pkg.
`default_nettype none
module prf_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quot
);
    import prf_pkg::*;

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [6:0]           cnt_reg,  cnt_next;
    logic [NUM_W-1:0]     nsh_reg,  nsh_next;
    logic [63:0]          r_reg,    r_next;
    logic [63:0]          q_reg,    q_next;
    logic [63:0]          den_reg,  den_next;
    logic                 ovf_reg,  ovf_next;

    logic [64:0] r_shift;
    logic [64:0] r_diff;
    logic        ge;

    // One restoring step
    always_comb
    begin
        r_shift = {r_reg, nsh_reg[NUM_W-1]};
        ge      = (r_shift >= {1'b0, den_reg});
        r_diff  = r_shift - {1'b0, den_reg};
    end

    // Sequence the steps
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        nsh_next  = nsh_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 7'(NUM_W - 1);
            nsh_next = {num, 16'b0};
            r_next   = '0;
            q_next   = '0;
            den_next = den;
            ovf_next = 1'b0;
        end
        else if (run_reg)
        begin
            nsh_next = {nsh_reg[NUM_W-2:0], 1'b0};
            r_next   = ge ? r_diff[63:0] : r_shift[63:0];
            q_next   = {q_reg[62:0], ge};
            ovf_next = ovf_reg | q_reg[63];
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath values
    always_ff @(posedge clk)
    begin
        nsh_reg <= nsh_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = (ovf_reg || q_reg[63]) ? QCAP : q_reg;

endmodule
`default_nettype wire

>>> bench/pairwise_repulsive_force_test.sv
// Self-checking testbench for pairwise_repulsive_force: directed table, strength extremes, then random node sets.
// Depends on prf_pkg and the pairwise_repulsive_force RTL only.
`timescale 1ns / 100ps
`default_nettype none
module pairwise_repulsive_force_test;
    import prf_pkg::*;

    localparam int NODE_CAP = 64;
    localparam longint unsigned TERM_CAP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        bit          last;
        bit          typed;
        logic [31:0] fx;
        logic [31:0] fy;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    node_in_t    in_item;
    logic        busy;
    logic        result_valid;
    force_out_t  result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // Predictor state
    logic [31:0] held_x [NODE_CAP];
    logic [31:0] held_y [NODE_CAP];
    int          held_count;
    logic [31:0] strength_k;
    force_out_t  pending_forces [$];

    int          mismatches;
    int          items_sent;
    int          burst_left;
    bit          steady_mode;
    table_row_t  directed [$];

    pairwise_repulsive_force DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .in_item      (in_item),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Clock, 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // floor(mag * k * 2^16 / den), clipped to the largest term
    function automatic longint unsigned scaled_term(longint unsigned mag, longint unsigned k,
                                                    longint unsigned den);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, mag * k} << 16;
        q = num / {64'd0, den};
        if (q > {64'd0, TERM_CAP})
            return TERM_CAP;
        return q[63:0];
    endfunction

    function automatic longint clip_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Store an accepted node and, on the last flag, queue one force per held node
    task automatic predict_forces(node_in_t item);
        longint          sx, sy, dx, dy;
        longint unsigned ax, ay, sqx, den, mx, my;
        force_out_t      f;
        if (held_count < NODE_CAP)
        begin
            held_x[held_count] = item.pos_x;
            held_y[held_count] = item.pos_y;
            held_count++;
        end
        if (!item.last_node)
            return;
        for (int i = 0; i < held_count; i++)
        begin
            sx = 0;
            sy = 0;
            for (int j = 0; j < held_count; j++)
            begin
                if (i == j)
                    continue;
                dx = longint'($signed(held_x[i])) - longint'($signed(held_x[j]));
                dy = longint'($signed(held_y[i])) - longint'($signed(held_y[j]));
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                sqx = ax * ax;
                den = sqx + ay * ay;
                if (den < sqx)
                    den = 64'hFFFF_FFFF_FFFF_FFFF;
                // Coincident nodes: unit distance, fixed small push by index order
                if (den < NEAR_THRESH)
                begin
                    den = ONE_Q32;
                    dx = (i > j) ? 64'sd655 : -64'sd655;
                    dy = dx;
                end
                mx = scaled_term((dx < 0) ? -dx : dx, strength_k, den);
                my = scaled_term((dy < 0) ? -dy : dy, strength_k, den);
                sx = clip_add(sx, (dx < 0) ? -longint'(mx) : longint'(mx));
                sy = clip_add(sy, (dy < 0) ? -longint'(my) : longint'(my));
            end
            f.node_index  = i[5:0];
            f.force_x     = clip32(sx);
            f.force_y     = clip32(sy);
            f.last_result = (i + 1 == held_count);
            pending_forces.push_back(f);
        end
        held_count = 0;
    endtask

    // Check each force transaction against the oldest expectation
    always @(posedge clk)
    begin
        force_out_t want;
        if (rst_n && result_valid)
        begin
            if (pending_forces.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected force: idx %0d fx %h fy %h", result.node_index,
                             result.force_x, result.force_y);
            end
            else
            begin
                want = pending_forces.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("force mismatch: exp idx %0d fx %h fy %h last %b, got idx %0d fx %h fy %h last %b",
                                 want.node_index, want.force_x, want.force_y, want.last_result,
                                 result.node_index, result.force_x, result.force_y,
                                 result.last_result);
                end
            end
        end
    end

    // Present one node and hold it until accepted; between bursts, idle unless in steady mode
    task automatic send_node(logic [31:0] x, logic [31:0] y, bit last);
        node_in_t item;
        int       gap;
        item.pos_x = x;
        item.pos_y = y;
        item.last_node = last;
        start <= 1'b1;
        in_item <= item;
        do
            @(posedge clk);
        while (busy);
        predict_forces(item);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0)
            steady_mode = !steady_mode;
        if (!steady_mode)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain all forces, let the block settle, then write the strength register
    task automatic write_strength(logic [31:0] k);
        start <= 1'b0;
        @(posedge clk);
        while (pending_forces.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= k;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        strength_k = k;
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            default: return 32'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic table_row_t row(logic [31:0] x, logic [31:0] y, bit last,
                                       bit typed = 0, logic [31:0] fx = 0,
                                       logic [31:0] fy = 0);
        table_row_t r;
        r.x = x;
        r.y = y;
        r.last = last;
        r.typed = typed;
        r.fx = fx;
        r.fy = fy;
        return r;
    endfunction

    initial
    begin
        force_out_t f;
        int         set_size;
        int         mode;
        logic [31:0] bx, by;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        held_count = 0;
        strength_k = K_RESET;
        mismatches = 0;
        items_sent = 0;
        burst_left = 0;
        steady_mode = 0;

        // Directed table; typed rows give the force of the set's final node
        directed.push_back(row(32'd5, 32'd5, 1, 1, 32'd0, 32'd0));
        directed.push_back(row(32'd0, 32'd0, 0));
        directed.push_back(row(32'd0, 32'd0, 1, 1, 32'd655, 32'd655));
        directed.push_back(row(32'h8000_0000, 32'h8000_0000, 0));
        directed.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        directed.push_back(row(32'h7FFF_FFFF, 32'h8000_0000, 0));
        directed.push_back(row(32'h8000_0000, 32'h7FFF_FFFF, 0));
        directed.push_back(row(32'd0, 32'd0, 1));
        directed.push_back(row(32'd0, 32'd0, 0));
        directed.push_back(row(32'd46, 32'd46, 1));
        directed.push_back(row(32'd0, 32'd0, 0));
        directed.push_back(row(32'd47, 32'd47, 1));
        directed.push_back(row(32'hFFFF_0000, 32'h0001_0000, 0));
        directed.push_back(row(32'h0001_0000, 32'hFFFF_0000, 0));
        directed.push_back(row(32'h1234_5678, 32'hFFFF_EDCC, 1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            // Return straight after acceptance so the expectation is still queued
            if (directed[r].typed && burst_left == 0)
                burst_left = 1;
            send_node(directed[r].x, directed[r].y, directed[r].last);
            if (directed[r].typed)
            begin
                f = pending_forces.pop_back();
                f.force_x = directed[r].fx;
                f.force_y = directed[r].fy;
                pending_forces.push_back(f);
            end
        end

        // Strength extremes on a close pair and a spread trio
        write_strength(32'd0);
        send_node(32'd0, 32'd0, 0);
        send_node(32'h0001_0000, 32'd0, 1);
        write_strength(32'hFFFF_FFFF);
        send_node(32'd0, 32'd0, 0);
        send_node(32'h0000_1000, 32'd0, 0);
        send_node(32'hFFFF_F000, 32'h0000_0100, 1);

        // Random sets, mostly small; one overflowing set where the dropped node ends it
        for (int s = 0; items_sent < 420; s++)
        begin
            if (s % 12 == 0)
                case ($urandom_range(0, 3))
                    0: write_strength(32'd0);
                    1: write_strength(32'hFFFF_FFFF);
                    2: write_strength(K_RESET);
                    default: write_strength($urandom());
                endcase
            if (s == 30)
            begin
                for (int n = 0; n <= NODE_CAP; n++)
                    send_node(pick_coord(2), pick_coord(1), n == NODE_CAP);
                continue;
            end
            set_size = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                   : $urandom_range(1, 5);
            mode = $urandom_range(0, 2);
            bx = pick_coord(mode);
            by = pick_coord(mode);
            for (int n = 0; n < set_size; n++)
            begin
                // Occasionally repeat a node to hit the coincident case
                if ($urandom_range(0, 7) != 0)
                begin
                    bx = pick_coord(mode);
                    by = pick_coord(mode);
                end
                send_node(bx, by, n == set_size - 1);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending_forces.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_forces.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard limit on run time
    initial
    begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/prf_pkg.sv
rtl/core/prf_ram.sv
rtl/core/prf_div.sv
rtl/core/pairwise_repulsive_force.sv
bench/pairwise_repulsive_force_test.sv
